FILE: rtl/mm3_pkg.sv
// ----------------------------------------------------------------------------
// MurmurHash3 stream hash package
// Constants, action codes and the controller/datapath command types.
// ----------------------------------------------------------------------------
package mm3_pkg;

    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] F1 = 32'h85ebca6b;
    localparam logic [31:0] F2 = 32'hc2b2ae35;

    localparam logic [1:0] ACT_FEED     = 2'd0;
    localparam logic [1:0] ACT_FEED_FIN = 2'd1;
    localparam logic [1:0] ACT_FIN      = 2'd2;
    localparam logic [1:0] ACT_NONE     = 2'd3;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_FEED,
        OP_MUL_C1,
        OP_MUL_C2,
        OP_MIX,
        OP_TAIL,
        OP_FOLD,
        OP_MUL_F1,
        OP_MUL_F2,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic pos_full;
        logic has_tail;
    } t_status;

endpackage

FILE: rtl/mm3_in_if.sv
// ----------------------------------------------------------------------------
// MurmurHash3 input channel
// Valid/ready channel that carries one action and one message byte.
// ----------------------------------------------------------------------------
interface mm3_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink (input valid, input action, input data_byte, output ready);
endinterface

FILE: rtl/mm3_out_if.sv
// ----------------------------------------------------------------------------
// MurmurHash3 output channel
// Valid/ready channel that carries one finished 32-bit hash.
// ----------------------------------------------------------------------------
interface mm3_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink (input valid, input hash_value, output ready);
endinterface

FILE: rtl/mm3_datapath.sv
// ----------------------------------------------------------------------------
// MurmurHash3 datapath
// Byte collection, running hash, byte count, one shared 32x32 multiplier
// and the output hash register.
// ----------------------------------------------------------------------------
module mm3_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mm3_pkg::t_cmd   i_cmd,
    input  logic [7:0]      i_data_byte,
    output mm3_pkg::t_status o_status,
    output logic [31:0]     o_hash_value
);
    import mm3_pkg::*;

    logic [31:0] r_hash;
    logic [31:0] r_total;
    logic [31:0] r_acc;
    logic [31:0] r_hash_out;
    logic [1:0]  r_pos;
    logic [7:0]  r_pend [3];

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] prod;
    logic [31:0] mix_x;
    logic [31:0] mix_r;
    logic [31:0] fold_x;

    always_comb begin
        unique case (i_cmd.op)
            OP_MUL_C2: begin
                mul_a = {r_acc[16:0], r_acc[31:17]};
                mul_b = C2;
            end
            OP_MUL_F1: begin
                mul_a = r_acc;
                mul_b = F1;
            end
            OP_MUL_F2: begin
                mul_a = r_acc ^ (r_acc >> 13);
                mul_b = F2;
            end
            default: begin
                mul_a = r_acc;
                mul_b = C1;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign mix_x  = r_hash ^ r_acc;
    assign mix_r  = {mix_x[18:0], mix_x[31:19]};
    assign fold_x = r_hash ^ r_total ^ (o_status.has_tail ? r_acc : 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= '0;
            r_total <= '0;
            r_pos   <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_FEED: begin
                    r_total <= r_total + 32'd1;
                    if (r_pos == 2'd3) begin
                        r_pos <= '0;
                    end else begin
                        r_pos <= r_pos + 2'd1;
                    end
                end
                OP_MIX: begin
                    r_hash <= (mix_r << 2) + mix_r + MIX_ADD;
                end
                OP_EMIT: begin
                    r_hash  <= '0;
                    r_total <= '0;
                    r_pos   <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_FEED: begin
                if (r_pos == 2'd3) begin
                    r_acc <= {i_data_byte, r_pend[2], r_pend[1], r_pend[0]};
                end else begin
                    r_pend[r_pos] <= i_data_byte;
                end
            end
            OP_MUL_C1, OP_MUL_C2, OP_MUL_F1, OP_MUL_F2: begin
                r_acc <= prod;
            end
            OP_TAIL: begin
                r_acc <= {8'h00,
                          (r_pos == 2'd3) ? r_pend[2] : 8'h00,
                          (r_pos >= 2'd2) ? r_pend[1] : 8'h00,
                          r_pend[0]};
            end
            OP_FOLD: begin
                r_acc <= fold_x ^ (fold_x >> 16);
            end
            OP_EMIT: begin
                r_hash_out <= r_acc ^ (r_acc >> 16);
            end
            default: begin
            end
        endcase
    end

    assign o_status.pos_full = (r_pos == 2'd3);
    assign o_status.has_tail = (r_pos != 2'd0);
    assign o_hash_value      = r_hash_out;

endmodule

FILE: rtl/mm3_ctrl.sv
// ----------------------------------------------------------------------------
// MurmurHash3 controller
// Sequences block mixing, tail folding and the final avalanche, and owns
// both channel handshakes.
// ----------------------------------------------------------------------------
module mm3_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_action,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  mm3_pkg::t_status i_status,
    output mm3_pkg::t_cmd    o_cmd
);
    import mm3_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_C1,
        S_C2,
        S_MIX,
        S_TAIL,
        S_T1,
        S_T2,
        S_FOLD,
        S_F1,
        S_F2,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_fin;
    logic   n_fin;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        n_fin      = r_fin;
        o_cmd.op   = OP_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_FEED: begin
                            o_cmd.op = OP_FEED;
                            n_fin    = 1'b0;
                            if (i_status.pos_full) begin
                                n_state = S_C1;
                            end
                        end
                        ACT_FEED_FIN: begin
                            o_cmd.op = OP_FEED;
                            n_fin    = 1'b1;
                            n_state  = i_status.pos_full ? S_C1 : S_TAIL;
                        end
                        ACT_FIN: begin
                            n_state = i_status.has_tail ? S_TAIL : S_FOLD;
                        end
                        ACT_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_C1: begin
                o_cmd.op = OP_MUL_C1;
                n_state  = S_C2;
            end
            S_C2: begin
                o_cmd.op = OP_MUL_C2;
                n_state  = S_MIX;
            end
            S_MIX: begin
                o_cmd.op = OP_MIX;
                n_state  = r_fin ? S_FOLD : S_IDLE;
            end
            S_TAIL: begin
                o_cmd.op = OP_TAIL;
                n_state  = S_T1;
            end
            S_T1: begin
                o_cmd.op = OP_MUL_C1;
                n_state  = S_T2;
            end
            S_T2: begin
                o_cmd.op = OP_MUL_C2;
                n_state  = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.op = OP_FOLD;
                n_state  = S_F1;
            end
            S_F1: begin
                o_cmd.op = OP_MUL_F1;
                n_state  = S_F2;
            end
            S_F2: begin
                o_cmd.op = OP_MUL_F2;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            if (o_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/murmur3_32_stream_hash.sv
// ----------------------------------------------------------------------------
// MurmurHash3 x86_32 stream hash
// Hashes a byte stream with seed zero and returns one 32-bit hash per message.
// ----------------------------------------------------------------------------
// Each request on i_in carries an action and a byte. Action 0 feeds a byte,
// action 1 feeds a byte and finishes the message, action 2 finishes without
// a byte, and action 3 is taken and ignored.
// A byte that does not complete a 4-byte block is only stored and counted.
// A byte that completes a block also sends the block through the single
// shared 32x32 multiplier twice and then through the hash mix step.
// A finish loads the leftover bytes as a tail block when there are any and
// scrambles them, then runs fold and avalanche, again through the shared
// multiplier. The last step writes the output register and sets o_out.valid.
// The output register lets the next message start while a hash waits. If the
// receiver holds o_out.ready low, a second finish stops before writing the
// output register until the first hash is taken, and i_in stays not ready.
// After reset the hash state, byte count and output valid are all clear.
// ----------------------------------------------------------------------------
module murmur3_32_stream_hash (
    input  logic  i_clk,
    input  logic  i_rst_n,
    mm3_in_if.sink    i_in,
    mm3_out_if.source o_out
);
    import mm3_pkg::*;

    t_cmd    cmd;
    t_status status;

    mm3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_action    (i_in.action),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mm3_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_data_byte  (i_in.data_byte),
        .o_status     (status),
        .o_hash_value (o_out.hash_value)
    );

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_EMIT |-> (!o_out.valid || o_out.ready))
        else $error("hash written while previous hash still pending");

    a_feed_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_FEED |-> (i_in.valid && i_in.ready))
        else $error("byte stored without an accepted request");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op != OP_IDLE && cmd.op != OP_FEED) |-> !i_in.ready)
        else $error("input ready while the datapath is busy");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_EMIT |=> o_out.valid)
        else $error("finished hash not presented");

endmodule

FILE: tb/tb_murmur3_32_stream_hash.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MurmurHash3 x86_32 stream hash testbench
// Drives byte requests through the input channel and checks every finished
// hash against a shadow hash computed alongside. A short directed set covers
// empty messages, ignored actions, extreme bytes and every tail length. A
// long random set of messages with random stalls on both channels follows,
// including one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_murmur3_32_stream_hash;
    import mm3_pkg::*;

    localparam int unsigned RANDOM_REQS = 530;
    localparam int unsigned HOLD_AT     = 150;
    localparam int unsigned HOLD_LEN    = 200;
    localparam int unsigned CALM_TAIL   = 100;
    localparam int unsigned CYCLE_LIMIT = 60000;

    typedef struct {
        logic [1:0] action;
        logic [7:0] data_byte;
    } t_hash_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic       src_valid = 1'b0;
    logic [1:0] src_action = ACT_FEED;
    logic [7:0] src_byte = 8'h00;
    logic       sink_ready = 1'b0;

    mm3_in_if  in_ch ();
    mm3_out_if out_ch ();

    assign in_ch.valid     = src_valid;
    assign in_ch.action    = src_action;
    assign in_ch.data_byte = src_byte;
    assign out_ch.ready    = sink_ready;

    murmur3_32_stream_hash dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    t_hash_req   pending_reqs[$];
    logic [31:0] expected_hashes[$];
    int unsigned total_reqs = 0;
    int unsigned reqs_accepted = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned hold_left = 0;
    bit          hold_started = 1'b0;

    // Shadow hash state.
    logic [31:0] shadow_hash = 32'h0;
    logic [7:0]  shadow_tail[3] = '{8'h00, 8'h00, 8'h00};
    logic [1:0]  shadow_tail_cnt = 2'd0;
    logic [31:0] shadow_len = 32'h0;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] block_scramble(input logic [31:0] k);
        logic [31:0] t;
        t = k * C1;
        t = rotl32(t, 15);
        return t * C2;
    endfunction

    function automatic logic [31:0] final_mix(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * F1;
        t = t ^ (t >> 13);
        t = t * F2;
        return t ^ (t >> 16);
    endfunction

    function automatic void clear_shadow();
        shadow_hash = 32'h0;
        shadow_tail = '{8'h00, 8'h00, 8'h00};
        shadow_tail_cnt = 2'd0;
        shadow_len = 32'h0;
    endfunction

    function automatic void track_request(input logic [1:0] act, input logic [7:0] b);
        logic [31:0] k;
        logic [31:0] h;
        if (act == ACT_NONE) begin
            return;
        end
        if (act == ACT_FEED || act == ACT_FEED_FIN) begin
            if (shadow_tail_cnt == 2'd3) begin
                k = {b, shadow_tail[2], shadow_tail[1], shadow_tail[0]};
                shadow_hash = rotl32(shadow_hash ^ block_scramble(k), 13);
                shadow_hash = shadow_hash * 32'd5 + MIX_ADD;
                shadow_tail_cnt = 2'd0;
            end else begin
                shadow_tail[shadow_tail_cnt] = b;
                shadow_tail_cnt = shadow_tail_cnt + 2'd1;
            end
            shadow_len = shadow_len + 32'd1;
        end
        if (act == ACT_FEED) begin
            return;
        end
        h = shadow_hash;
        k = 32'h0;
        if (shadow_tail_cnt >= 2'd3) k = k ^ {8'h00, shadow_tail[2], 16'h0000};
        if (shadow_tail_cnt >= 2'd2) k = k ^ {16'h0000, shadow_tail[1], 8'h00};
        if (shadow_tail_cnt >= 2'd1) begin
            k = k ^ {24'h000000, shadow_tail[0]};
            h = h ^ block_scramble(k);
        end
        h = h ^ shadow_len;
        expected_hashes.push_back(final_mix(h));
        clear_shadow();
    endfunction

    function automatic void add_req(input logic [1:0] act, input logic [7:0] b);
        t_hash_req r;
        r.action = act;
        r.data_byte = b;
        pending_reqs.push_back(r);
    endfunction

    // Request driver.
    always @(posedge i_clk) begin
        t_hash_req req;
        if (!i_rst_n) begin
            src_valid <= 1'b0;
        end else begin
            if (src_valid && in_ch.ready) begin
                track_request(src_action, src_byte);
                reqs_accepted++;
            end
            if (!src_valid || in_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    src_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    req = pending_reqs.pop_front();
                    src_valid <= 1'b1;
                    src_action <= req.action;
                    src_byte <= req.data_byte;
                    if (reqs_accepted + CALM_TAIL < total_reqs && $urandom_range(0, 4) == 0) begin
                        src_gap = $urandom_range(1, 3);
                    end
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // Hash monitor and output stall control.
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (out_ch.valid && sink_ready) begin
                if (expected_hashes.size() == 0) begin
                    $display("%0t: unexpected hash, expected none, actual %08h",
                             $time, out_ch.hash_value);
                    err_count++;
                end else begin
                    want = expected_hashes.pop_front();
                    if (out_ch.hash_value !== want) begin
                        $display("%0t: hash mismatch, expected %08h, actual %08h",
                                 $time, want, out_ch.hash_value);
                        err_count++;
                    end
                end
            end
            if (!hold_started && reqs_accepted >= HOLD_AT) begin
                hold_started = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                sink_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                sink_ready <= 1'b0;
            end else begin
                sink_ready <= 1'b1;
                if (reqs_accepted + CALM_TAIL < total_reqs && $urandom_range(0, 4) == 0) begin
                    sink_gap = $urandom_range(1, 3);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int unsigned counted;
        int unsigned msg_len;

        // Directed requests.
        add_req(ACT_FIN, 8'h00);
        add_req(ACT_NONE, 8'hff);
        add_req(ACT_FEED_FIN, 8'h00);
        add_req(ACT_FEED_FIN, 8'hff);
        add_req(ACT_FEED, 8'h61);
        add_req(ACT_FEED, 8'h62);
        add_req(ACT_NONE, 8'h5a);
        add_req(ACT_FEED, 8'h63);
        add_req(ACT_FEED_FIN, 8'h64);
        for (int i = 0; i < 5; i++) begin
            add_req(ACT_FEED, (i == 4) ? 8'hff : 8'h80 + i[7:0]);
        end
        add_req(ACT_FIN, 8'ha5);
        add_req(ACT_FEED, 8'h01);
        add_req(ACT_FEED, 8'hfe);
        add_req(ACT_FIN, 8'hff);
        add_req(ACT_FEED, 8'hff);
        add_req(ACT_FEED, 8'hff);
        add_req(ACT_FEED, 8'hff);
        add_req(ACT_FIN, 8'h00);
        add_req(ACT_FIN, 8'h3c);

        // Random messages with ignored requests mixed in.
        counted = 0;
        while (counted < RANDOM_REQS) begin
            if ($urandom_range(0, 7) == 0) begin
                msg_len = $urandom_range(0, 40);
            end else begin
                msg_len = $urandom_range(0, 9);
            end
            for (int i = 0; i < msg_len; i++) begin
                if ($urandom_range(0, 11) == 0) begin
                    add_req(ACT_NONE, 8'($urandom));
                end
                if (i == msg_len - 1 && $urandom_range(0, 1) == 0) begin
                    add_req(ACT_FEED_FIN, 8'($urandom));
                end else begin
                    add_req(ACT_FEED, 8'($urandom));
                    if (i == msg_len - 1) begin
                        add_req(ACT_FIN, 8'($urandom));
                        counted++;
                    end
                end
                counted++;
            end
            if (msg_len == 0) begin
                add_req(ACT_FIN, 8'($urandom));
                counted++;
            end
        end
        total_reqs = pending_reqs.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || src_valid || expected_hashes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
